FILE: rtl/state_feedback_current_estimator_unit_defines.svh
// assertion macros for the state feedback current estimator unit
`ifndef STATE_FEEDBACK_CURRENT_ESTIMATOR_UNIT_DEFINES_SVH
`define STATE_FEEDBACK_CURRENT_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SFCE_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SFCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sfce_pkg.sv
// shared types, constants and fixed-point helpers for the estimator unit
package sfce_pkg;

    localparam int VOLT_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int DAC_BITS   = 8;
    localparam int CFG_W      = 15;
    localparam int CFG_ADDR_W = 2;

    localparam int COEF_W = FRAC_BITS + 3;
    localparam int OPND_W = VOLT_WIDTH + 1;
    localparam int PROD_W = COEF_W + OPND_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int WIDE_W = VOLT_WIDTH + 2;
    localparam int Q_W    = ACC_W + 1 - FRAC_BITS;
    localparam int DVD_W  = CFG_W + DAC_BITS;

    localparam int S_TDATA_W = ((1 + VOLT_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * DAC_BITS + 7) / 8) * 8;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MEAS = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_SAT_MIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAT_MAX  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MID_SUP  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REF_HALF = 2'd3;

    localparam logic [CFG_W-1:0] SAT_MIN_RST  = 15'd0;
    localparam logic [CFG_W-1:0] SAT_MAX_RST  = 15'd16712;
    localparam logic [CFG_W-1:0] MID_SUP_RST  = 15'd10240;
    localparam logic [CFG_W-1:0] REF_HALF_RST = 15'd4096;

    localparam logic [DAC_BITS-1:0] DAC_FULL = '1;

    localparam logic signed [VOLT_WIDTH-1:0] VMAX = {1'b0, {(VOLT_WIDTH-1){1'b1}}};
    localparam logic signed [VOLT_WIDTH-1:0] VMIN = {1'b1, {(VOLT_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] W_VMAX = WIDE_W'(VMAX);
    localparam logic signed [WIDE_W-1:0] W_VMIN = WIDE_W'(VMIN);
    localparam logic signed [Q_W-1:0] Q_VMAX = Q_W'(VMAX);
    localparam logic signed [Q_W-1:0] Q_VMIN = Q_W'(VMIN);
    localparam logic signed [ACC_W:0] ROUND_HALF =
        $signed({{(ACC_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});

    // coefficient from millionths, rounded to nearest
    function automatic longint qc(input longint micro);
        return ((micro <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    endfunction

    localparam logic signed [COEF_W-1:0] C_A11 = COEF_W'(qc(932581));
    localparam logic signed [COEF_W-1:0] C_A21 = COEF_W'(-qc(1145618));
    localparam logic signed [COEF_W-1:0] C_A22 = COEF_W'(qc(455938));
    localparam logic signed [COEF_W-1:0] C_B1  = COEF_W'(-qc(117824));
    localparam logic signed [COEF_W-1:0] C_B2  = COEF_W'(qc(80093));
    localparam logic signed [COEF_W-1:0] C_K1  = COEF_W'(qc(2907022));
    localparam logic signed [COEF_W-1:0] C_K2  = COEF_W'(qc(1636048));
    localparam logic signed [COEF_W-1:0] C_K0  = COEF_W'(qc(569878));
    localparam logic signed [COEF_W-1:0] C_L1  = COEF_W'(-qc(503374));
    localparam logic signed [COEF_W-1:0] C_L2  = COEF_W'(qc(988519));

    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
    } mac_ctrl_t;

    function automatic logic signed [VOLT_WIDTH-1:0] sat_wide(
        input logic signed [WIDE_W-1:0] v);
        if (v > W_VMAX) begin
            return VMAX;
        end else if (v < W_VMIN) begin
            return VMIN;
        end
        return v[VOLT_WIDTH-1:0];
    endfunction

    // divide by 2^FRAC_BITS, round half up, saturate
    function automatic logic signed [VOLT_WIDTH-1:0] scale_down(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0] t;
        logic signed [Q_W-1:0] q;
        t = $signed({v[ACC_W-1], v}) + ROUND_HALF;
        q = t[ACC_W:FRAC_BITS];
        if (q > Q_VMAX) begin
            return VMAX;
        end else if (q < Q_VMIN) begin
            return VMIN;
        end
        return q[VOLT_WIDTH-1:0];
    endfunction

    // raise to min, then lower to max; result is never negative
    function automatic logic [CFG_W-1:0] code_clamp(
        input logic signed [WIDE_W-1:0] v,
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (c < $signed(WIDE_W'(lo))) begin
            c = $signed(WIDE_W'(lo));
        end
        if (c > $signed(WIDE_W'(hi))) begin
            c = $signed(WIDE_W'(hi));
        end
        return c[CFG_W-1:0];
    endfunction

    function automatic logic [DAC_BITS-1:0] code_pick(
        input logic [CFG_W-1:0] vc,
        input logic [CFG_W-1:0] hi,
        input logic [DAC_BITS-1:0] quo);
        if (hi == '0 || vc == '0) begin
            return '0;
        end else if (vc >= hi) begin
            return DAC_FULL;
        end
        return quo;
    endfunction

endpackage

FILE: rtl/state_feedback_current_estimator_unit.sv
// top level: sequencer, estimator state and stream ports of the regulator
//
// channel  | ports                         | payload
// input    | s_tvalid s_tready s_tdata s_tuser | operation, ref_high, measured_ac_volts
// result   | m_tvalid m_tready m_tdata     | drive_dac_code, ref_dac_code
// config   | cfg_wr_en cfg_addr cfg_wr_data | four 15-bit registers
//
// a measurement request runs the correction steps; a control tick runs the control law, the prediction
// and two divisions, sequenced over the single multiply-accumulate unit and the bit-serial divider
// aresetn clears estimate, prediction and registers to their reset values
// s_tready is high only between requests; a result held by m_tready stalls the next tick
`include "state_feedback_current_estimator_unit_defines.svh"

module state_feedback_current_estimator_unit import sfce_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,      // ref_high, measured_ac_volts
    input  logic                  s_tuser,      // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // drive_dac_code, ref_dac_code
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] ST_M_L1  = 5'd1;
    localparam logic [ST_W-1:0] ST_M_E1  = 5'd2;
    localparam logic [ST_W-1:0] ST_M_E2  = 5'd3;
    localparam logic [ST_W-1:0] ST_T_K0  = 5'd4;
    localparam logic [ST_W-1:0] ST_T_K1  = 5'd5;
    localparam logic [ST_W-1:0] ST_T_K2  = 5'd6;
    localparam logic [ST_W-1:0] ST_T_U   = 5'd7;
    localparam logic [ST_W-1:0] ST_T_A11 = 5'd8;
    localparam logic [ST_W-1:0] ST_T_B1  = 5'd9;
    localparam logic [ST_W-1:0] ST_T_A21 = 5'd10;
    localparam logic [ST_W-1:0] ST_T_A22 = 5'd11;
    localparam logic [ST_W-1:0] ST_T_B2  = 5'd12;
    localparam logic [ST_W-1:0] ST_T_P2  = 5'd13;
    localparam logic [ST_W-1:0] ST_T_DD  = 5'd14;
    localparam logic [ST_W-1:0] ST_T_DR  = 5'd15;
    localparam logic [ST_W-1:0] ST_T_OUT = 5'd16;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    logic [CFG_W-1:0] sat_min_reg;
    logic [CFG_W-1:0] sat_max_reg;
    logic [CFG_W-1:0] mid_sup_reg;
    logic [CFG_W-1:0] ref_half_reg;

    logic signed [VOLT_WIDTH-1:0] est1_reg;
    logic signed [VOLT_WIDTH-1:0] est2_reg;
    logic signed [VOLT_WIDTH-1:0] pred1_reg;
    logic signed [VOLT_WIDTH-1:0] pred2_reg;

    logic signed [OPND_W-1:0]     innov_reg;
    logic signed [VOLT_WIDTH-1:0] ref_reg;
    logic signed [VOLT_WIDTH-1:0] u_apl_reg;
    logic [CFG_W-1:0]             drive_vc_reg;
    logic [CFG_W-1:0]             ref_vc_reg;
    logic [DAC_BITS-1:0]          drive_code_reg;
    logic [DAC_BITS-1:0]          ref_code_reg;
    logic                         m_tvalid_reg;
    logic [M_TDATA_W-1:0]         m_tdata_reg;

    logic                         in_fire;
    logic                         out_load;
    mac_ctrl_t                    mac_ctrl;
    logic signed [OPND_W-1:0]     mac_opnd;
    logic signed [COEF_W-1:0]     mac_coef;
    logic signed [VOLT_WIDTH-1:0] mac_scaled;
    logic                         div_start;
    logic                         div_done;
    logic [DVD_W-1:0]             div_dividend;
    logic [DAC_BITS-1:0]          div_quo;

    logic signed [VOLT_WIDTH-1:0] in_y;
    logic signed [WIDE_W-1:0]     ref_wide;
    logic signed [WIDE_W-1:0]     u_sum;
    logic signed [WIDE_W-1:0]     u_phys;
    logic signed [VOLT_WIDTH-1:0] u_apl;
    logic [CFG_W-1:0]             u_phys_vc;
    logic [CFG_W-1:0]             ref_vc;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_y     = $signed(s_tdata[VOLT_WIDTH:1]);

    // reference and control-voltage datapath around the mac
    always_comb begin
        ref_wide = $signed(WIDE_W'(ref_half_reg));
        if (!s_tdata[0]) begin
            ref_wide = -ref_wide;
        end
        u_sum  = WIDE_W'(mac_scaled) + $signed(WIDE_W'(mid_sup_reg));
        u_phys = u_sum;
        if (u_phys > $signed(WIDE_W'(sat_max_reg))) begin
            u_phys = $signed(WIDE_W'(sat_max_reg));
        end
        if (u_phys < $signed(WIDE_W'(sat_min_reg))) begin
            u_phys = $signed(WIDE_W'(sat_min_reg));
        end
        u_apl     = sat_wide(u_phys - $signed(WIDE_W'(mid_sup_reg)));
        u_phys_vc = code_clamp(u_phys, sat_min_reg, sat_max_reg);
        ref_vc    = code_clamp(WIDE_W'(ref_reg) + $signed(WIDE_W'(mid_sup_reg)),
                               sat_min_reg, sat_max_reg);
    end

    always_comb begin
        state_next   = state_reg;
        mac_ctrl     = '0;
        mac_opnd     = '0;
        mac_coef     = '0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        div_dividend = DVD_W'(drive_vc_reg) * DVD_W'(DAC_FULL);
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_tuser == OP_MEAS) ? ST_M_L1 : ST_T_K0;
                end
            end
            ST_M_L1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                mac_opnd   = innov_reg;
                mac_coef   = C_L1;
                state_next = ST_M_E1;
            end
            ST_M_E1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                mac_opnd   = innov_reg;
                mac_coef   = C_L2;
                state_next = ST_M_E2;
            end
            ST_M_E2: begin
                state_next = ST_IDLE;
            end
            ST_T_K0: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                mac_opnd   = OPND_W'(ref_reg);
                mac_coef   = C_K0;
                state_next = ST_T_K1;
            end
            ST_T_K1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                mac_opnd   = OPND_W'(est1_reg);
                mac_coef   = C_K1;
                state_next = ST_T_K2;
            end
            ST_T_K2: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                mac_opnd   = OPND_W'(est2_reg);
                mac_coef   = C_K2;
                state_next = ST_T_U;
            end
            ST_T_U: begin
                state_next = ST_T_A11;
            end
            ST_T_A11: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                mac_opnd   = OPND_W'(est1_reg);
                mac_coef   = C_A11;
                state_next = ST_T_B1;
            end
            ST_T_B1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
                mac_opnd   = OPND_W'(u_apl_reg);
                mac_coef   = C_B1;
                state_next = ST_T_A21;
            end
            ST_T_A21: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                mac_opnd   = OPND_W'(est1_reg);
                mac_coef   = C_A21;
                state_next = ST_T_A22;
            end
            ST_T_A22: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
                mac_opnd   = OPND_W'(est2_reg);
                mac_coef   = C_A22;
                state_next = ST_T_B2;
            end
            ST_T_B2: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
                mac_opnd   = OPND_W'(u_apl_reg);
                mac_coef   = C_B2;
                state_next = ST_T_P2;
            end
            ST_T_P2: begin
                div_start  = 1'b1;
                state_next = ST_T_DD;
            end
            ST_T_DD: begin
                div_dividend = DVD_W'(ref_vc_reg) * DVD_W'(DAC_FULL);
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_T_DR;
                end
            end
            ST_T_DR: begin
                if (div_done) begin
                    state_next = ST_T_OUT;
                end
            end
            ST_T_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sfce_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .opnd   (mac_opnd),
        .coef   (mac_coef),
        .scaled (mac_scaled)
    );

    sfce_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (sat_max_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            sat_min_reg  <= SAT_MIN_RST;
            sat_max_reg  <= SAT_MAX_RST;
            mid_sup_reg  <= MID_SUP_RST;
            ref_half_reg <= REF_HALF_RST;
            est1_reg     <= '0;
            est2_reg     <= '0;
            pred1_reg    <= '0;
            pred2_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_SAT_MIN:  sat_min_reg  <= cfg_wr_data;
                    REG_SAT_MAX:  sat_max_reg  <= cfg_wr_data;
                    REG_MID_SUP:  mid_sup_reg  <= cfg_wr_data;
                    REG_REF_HALF: ref_half_reg <= cfg_wr_data;
                    default:      sat_min_reg  <= sat_min_reg;
                endcase
            end
            // correction starts from the stored prediction, which it leaves alone
            if (state_reg == ST_M_E1) begin
                est1_reg <= sat_wide(WIDE_W'(pred1_reg) + WIDE_W'(mac_scaled));
            end
            if (state_reg == ST_M_E2) begin
                est2_reg <= sat_wide(WIDE_W'(pred2_reg) + WIDE_W'(mac_scaled));
            end
            if (state_reg == ST_T_A21) begin
                pred1_reg <= mac_scaled;
            end
            if (state_reg == ST_T_P2) begin
                pred2_reg <= mac_scaled;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            innov_reg <= $signed({in_y[VOLT_WIDTH-1], in_y})
                       - $signed({pred2_reg[VOLT_WIDTH-1], pred2_reg});
            ref_reg   <= sat_wide(ref_wide);
        end
        if (state_reg == ST_T_U) begin
            u_apl_reg    <= u_apl;
            drive_vc_reg <= u_phys_vc;
            ref_vc_reg   <= ref_vc;
        end
        if (state_reg == ST_T_DD && div_done) begin
            drive_code_reg <= code_pick(drive_vc_reg, sat_max_reg, div_quo);
        end
        if (state_reg == ST_T_DR && div_done) begin
            ref_code_reg <= code_pick(ref_vc_reg, sat_max_reg, div_quo);
        end
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({ref_code_reg, drive_code_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SFCE_ASSERT_IMPLY(a_div_done_waiting, aclk, aresetn, div_done, (state_reg == ST_T_DD || state_reg == ST_T_DR), "divider finished outside a wait state")
    `SFCE_ASSERT_NEXT(a_meas_path, aclk, aresetn, (in_fire && s_tuser == OP_MEAS), (state_reg == ST_M_L1), "measurement request did not enter the correction path")
    `SFCE_ASSERT_IMPLY(a_result_from_tick, aclk, aresetn, $rose(m_tvalid_reg), ($past(state_reg) == ST_T_OUT), "result raised outside the tick output step")

endmodule

FILE: rtl/sfce_mac.sv
// shared multiply-accumulate unit with rounding scale-down of the sum
module sfce_mac import sfce_pkg::*; (
    input  logic                         aclk,
    input  mac_ctrl_t                    ctrl,
    input  logic signed [OPND_W-1:0]     opnd,
    input  logic signed [COEF_W-1:0]     coef,
    output logic signed [VOLT_WIDTH-1:0] scaled
);

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  base;
    logic signed [PROD_W-1:0] prod;

    assign prod = opnd * coef;

    always_comb begin
        base     = ctrl.clr ? '0 : acc_reg;
        acc_next = ctrl.sub ? base - ACC_W'(prod) : base + ACC_W'(prod);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign scaled = scale_down(acc_reg);

endmodule

FILE: rtl/sfce_div.sv
// bit-serial restoring divider for the dac code scaling
module sfce_div import sfce_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [CFG_W-1:0]    divisor,
    output logic                done,
    output logic [DAC_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(DAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DAC_BITS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CFG_W-1:0]    rem_reg;
    logic [DAC_BITS-1:0] lo_reg;
    logic [DAC_BITS-1:0] quo_reg;
    logic [CFG_W-1:0]    dvs_reg;
    logic [CFG_W:0]      trial;
    logic [CFG_W:0]      diff;
    logic                fits;

    // quotient fits in DAC_BITS, so the top part already sits below the divisor
    always_comb begin
        trial = {rem_reg, lo_reg[DAC_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DVD_W-1:DAC_BITS];
            lo_reg  <= dividend[DAC_BITS-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            lo_reg  <= {lo_reg[DAC_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[DAC_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sim/state_feedback_current_estimator_unit_test.sv
// self-checking bench for the state feedback regulator with current estimator
`timescale 1ns / 100ps

module state_feedback_current_estimator_unit_test;
    import sfce_pkg::*;

    typedef struct packed {
        logic              op;
        logic              ref_hi;
        logic signed [15:0] meas;
    } request_t;

    typedef struct packed {
        logic [7:0] drive;
        logic [7:0] refc;
    } dac_pair_t;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} idle_mode_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;    // ref_high, measured_ac_volts
    logic                  s_tuser = 1'b0;  // operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // drive_dac_code, ref_dac_code
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    state_feedback_current_estimator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1500000;
        $display("CHECK FAILED");
        $finish;
    end

    // fixed-point regulator model
    function automatic longint q_micro(input longint micro);
        return ((micro << FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    endfunction

    localparam longint K_A11 = q_micro(932581);
    localparam longint K_A21 = -q_micro(1145618);
    localparam longint K_A22 = q_micro(455938);
    localparam longint K_B1  = -q_micro(117824);
    localparam longint K_B2  = q_micro(80093);
    localparam longint K_K1  = q_micro(2907022);
    localparam longint K_K2  = q_micro(1636048);
    localparam longint K_K0  = q_micro(569878);
    localparam longint K_L1  = -q_micro(503374);
    localparam longint K_L2  = q_micro(988519);
    localparam longint DAC_TOP = (64'sd1 << DAC_BITS) - 1;
    localparam longint V_HI = 32767;
    localparam longint V_LO = -32768;

    longint lim_min = 0, lim_max = 16712, mid_volts = 10240, half_amp = 4096;
    longint est1 = 0, est2 = 0, pred1 = 0, pred2 = 0;

    function automatic longint clip_volts(input longint v);
        if (v > V_HI) return V_HI;
        if (v < V_LO) return V_LO;
        return v;
    endfunction

    function automatic longint round_q(input longint v);
        return clip_volts((v + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic logic [7:0] dac_of(input longint v);
        longint c;
        c = v;
        if (c < lim_min) c = lim_min;
        if (c > lim_max) c = lim_max;
        if (lim_max <= 0 || c <= 0) return 8'd0;
        if (c >= lim_max) return 8'(DAC_TOP);
        return 8'((c * DAC_TOP) / lim_max);
    endfunction

    dac_pair_t expected_codes[$];
    request_t  pending[$];
    int        mismatches = 0;
    int        codes_seen = 0;
    int        ticks_taken = 0;
    int        samples_taken = 0;

    task automatic regulate(input logic op, input logic hi, input longint y);
        longint innov, refv, u_ac, u_phys, u_apl;
        dac_pair_t d;
        if (op == OP_MEAS) begin
            innov = clip_volts(y) - pred2;
            est1 = clip_volts(pred1 + round_q(K_L1 * innov));
            est2 = clip_volts(pred2 + round_q(K_L2 * innov));
            samples_taken++;
        end else begin
            refv = clip_volts(hi ? half_amp : -half_amp);
            u_ac = round_q(K_K0 * refv - K_K1 * est1 - K_K2 * est2);
            u_phys = u_ac + mid_volts;
            if (u_phys > lim_max) u_phys = lim_max;
            if (u_phys < lim_min) u_phys = lim_min;
            u_apl = clip_volts(u_phys - mid_volts);
            d.drive = dac_of(u_phys);
            d.refc = dac_of(refv + mid_volts);
            expected_codes.push_back(d);
            pred1 = round_q(K_A11 * est1 + K_B1 * u_apl);
            pred2 = round_q(K_A21 * est1 + K_A22 * est2 + K_B2 * u_apl);
            ticks_taken++;
        end
    endtask

    function automatic int unsigned idle_draw(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    idle_mode_t send_mode = IDLE_NONE;
    idle_mode_t recv_mode = IDLE_NONE;

    // request driver
    request_t    staged_req;
    bit          staged = 1'b0;
    int unsigned send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                regulate(s_tuser, s_tdata[0], longint'($signed(s_tdata[16:1])));
            end
            if (!s_tvalid || s_tready) begin
                if (!staged && pending.size() > 0) begin
                    staged_req = pending.pop_front();
                    staged = 1'b1;
                    send_gap = idle_draw(send_mode);
                end
                if (staged && send_gap == 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= staged_req.op;
                    s_tdata <= S_TDATA_W'({staged_req.meas, staged_req.ref_hi});
                    staged = 1'b0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (staged) send_gap--;
                end
            end
        end
    end

    // result monitor
    int          hold_requests = 0;
    int          hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned recv_gap = 0;

    always @(posedge aclk) begin
        dac_pair_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                codes_seen++;
                if (expected_codes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result drive=%0d ref=%0d",
                                 m_tdata[7:0], m_tdata[15:8]);
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata[7:0] !== want.drive || m_tdata[15:8] !== want.refc) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at result %0d: drive exp %0d got %0d, ref exp %0d got %0d",
                                     codes_seen, want.drive, m_tdata[7:0],
                                     want.refc, m_tdata[15:8]);
                    end
                end
                recv_gap = idle_draw(recv_mode);
            end
            if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_request(input logic op, input logic hi, input logic signed [15:0] y);
        request_t r;
        r.op = op;
        r.ref_hi = hi;
        r.meas = y;
        pending.push_back(r);
    endtask

    task automatic wait_results();
        while (pending.size() > 0 || staged || s_tvalid || expected_codes.size() > 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SAT_MIN:  lim_min = val;
            REG_SAT_MAX:  lim_max = val;
            REG_MID_SUP:  mid_volts = val;
            REG_REF_HALF: half_amp = val;
        endcase
    endtask

    // block must be idle: last result out and any trailing measurement done
    task automatic load_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                               input logic [CFG_W-1:0] mid, input logic [CFG_W-1:0] half);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_SAT_MIN, lo);
        write_reg(REG_SAT_MAX, hi);
        write_reg(REG_MID_SUP, mid);
        write_reg(REG_REF_HALF, half);
        @(negedge aclk);
    endtask

    // mostly tick/measurement pairs, the rest random order
    task automatic random_requests(input int n);
        logic op;
        logic signed [15:0] y;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8) op = (i % 2 == 0) ? OP_TICK : OP_MEAS;
            else op = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: y = 16'($urandom);
                3: begin
                    case ($urandom_range(0, 3))
                        0: y = 16'sh7fff;
                        1: y = 16'sh8000;
                        2: y = 16'sh0000;
                        default: y = 16'shffff;
                    endcase
                end
                default: y = 16'($signed($urandom_range(0, 8191)) - 4096);
            endcase
            add_request(op, 1'($urandom_range(0, 1)), y);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: measurement before any tick, repeats, input extremes
        send_mode = IDLE_NONE;
        recv_mode = IDLE_NONE;
        add_request(OP_MEAS, 1'b0, 16'sd1000);
        add_request(OP_MEAS, 1'b1, 16'sd1000);
        add_request(OP_TICK, 1'b1, 16'sh0000);
        add_request(OP_TICK, 1'b0, 16'shffff);
        add_request(OP_MEAS, 1'b0, 16'sh7fff);
        add_request(OP_MEAS, 1'b0, 16'sh8000);
        add_request(OP_TICK, 1'b1, 16'sh7fff);
        add_request(OP_TICK, 1'b0, 16'sh8000);
        add_request(OP_MEAS, 1'b1, 16'sh0000);
        add_request(OP_MEAS, 1'b1, 16'sh0000);
        add_request(OP_TICK, 1'b1, 16'sh0000);
        add_request(OP_MEAS, 1'b0, 16'shffff);
        add_request(OP_TICK, 1'b0, 16'sh0000);
        add_request(OP_MEAS, 1'b0, 16'sd16384);
        add_request(OP_TICK, 1'b1, 16'sh0000);
        add_request(OP_TICK, 1'b1, 16'sh0000);
        add_request(OP_MEAS, 1'b1, -16'sd20000);
        add_request(OP_TICK, 1'b0, 16'sh0000);
        wait_results();
        send_mode = IDLE_FULL;
        recv_mode = IDLE_FULL;
        random_requests(200);

        // widest limits, full reference swing, receiver held off for a while
        load_limits(15'd0, 15'd32767, 15'd0, 15'd32767);
        add_request(OP_TICK, 1'b1, 16'sh0000);
        add_request(OP_MEAS, 1'b0, 16'sh8000);
        add_request(OP_TICK, 1'b0, 16'sh0000);
        add_request(OP_MEAS, 1'b0, 16'sh7fff);
        send_mode = IDLE_LIGHT;
        recv_mode = IDLE_LIGHT;
        random_requests(200);
        hold_requests++;

        // zero full scale
        load_limits(15'd0, 15'd0, 15'd10240, 15'd4096);
        send_mode = IDLE_FULL;
        recv_mode = IDLE_NONE;
        random_requests(150);

        // crossed limits
        load_limits(15'd20000, 15'd10000, 15'd8000, 15'd6000);
        add_request(OP_TICK, 1'b1, 16'sh0000);
        add_request(OP_TICK, 1'b0, 16'sh0000);
        add_request(OP_MEAS, 1'b1, 16'sh7fff);
        send_mode = IDLE_NONE;
        recv_mode = IDLE_FULL;
        random_requests(200);

        // all limits at the top, no reference swing
        load_limits(15'd32767, 15'd32767, 15'd32767, 15'd0);
        send_mode = IDLE_LIGHT;
        recv_mode = IDLE_FULL;
        random_requests(150);

        // smallest full scale
        load_limits(15'd0, 15'd1, 15'd0, 15'd1);
        send_mode = IDLE_FULL;
        recv_mode = IDLE_LIGHT;
        random_requests(100);

        // random settings, sender pausing halfway until the block drains
        for (int p = 0; p < 2; p++) begin
            load_limits(15'($urandom_range(0, 8000)), 15'($urandom_range(8000, 32767)),
                        15'($urandom), 15'($urandom_range(0, 12000)));
            send_mode = idle_mode_t'($urandom_range(0, 2));
            recv_mode = idle_mode_t'($urandom_range(0, 2));
            random_requests(100);
            wait_results();
            random_requests(100);
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d ticks and %0d measurements over 8 register settings",
                 ticks_taken, samples_taken);
        $display("%0d dac code pairs checked, %0d mismatches", codes_seen, mismatches);
        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
